@@ rtl/core/ffpa_pkg.sv @@
// Shared types, field widths and codes for the first-fit pool allocator.
`default_nettype none

package ffpa_pkg;

  // Field widths of the request and result channels.
  localparam int FUNC_W = 2;
  localparam int REQ_W  = 14;
  localparam int OFF_W  = 13;
  localparam int LRG_W  = 13;
  localparam int CFG_W  = 14;

  // Width of the word count needed by the largest request, header included.
  localparam int NEED_W = 12;
  // Width of the header index of the largest block offset.
  localparam int TGT_W  = 10;

  localparam int POOL_WORDS_DEF = 1024;
  localparam logic [CFG_W-1:0] CFG_RST = 14'd8192;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  block_offset;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] payload_offset;
    logic [LRG_W-1:0] largest_bytes;
  } out_t;

  // Control from the top level into the chain walker.
  typedef struct packed {
    logic start;
    logic fmt;
    logic res_ready;
  } ctl_t;

  // Status from the chain walker back to the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } sts_t;

  typedef enum logic [2:0] {
    ST_FMT,
    ST_IDLE,
    ST_START,
    ST_CHK,
    ST_MRG,
    ST_SPLIT,
    ST_DONE
  } ffpa_state_t;

endpackage

`default_nettype wire

@@ rtl/core/ffpa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ffpa_walk.sv @@
// Header store and the sequencer that walks, merges and splits the block chain.
`default_nettype none

module ffpa_walk #(
  parameter int POOL_WORDS = ffpa_pkg::POOL_WORDS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ffpa_pkg::ctl_t                     ctl,
  input  wire ffpa_pkg::in_t                      req,
  input  wire logic [$clog2(POOL_WORDS+1)-1:0]    pool_words,
  output      ffpa_pkg::sts_t                     sts,
  output      ffpa_pkg::out_t                     res
);

  import ffpa_pkg::*;

  localparam int PW_W  = $clog2(POOL_WORDS + 1);
  localparam int PS_W  = PW_W + 1;
  localparam int AW    = $clog2(POOL_WORDS);
  localparam int ENT_W = PW_W + 1;
  localparam int CW    = (PW_W > NEED_W) ? PW_W : NEED_W;

  // A header holds the block size in words and an allocated flag.
  typedef struct packed {
    logic            alloc;
    logic [PW_W-1:0] size;
  } ent_t;

  ffpa_state_t     state_r, state_nxt;
  in_t             req_r, req_nxt;
  logic [PW_W-1:0] p_r, p_nxt;
  ent_t            cur_r, cur_nxt;
  logic            fresh_r, fresh_nxt;
  logic [PW_W-1:0] best_r, best_nxt;
  out_t            res_r, res_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  ent_t             wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [ENT_W-1:0] rdata;

  ent_t             hdr;
  ent_t             nxh;
  logic [PS_W-1:0]  nx_sum;
  logic [PS_W-1:0]  cur_sum;
  logic [PW_W-1:0]  nx_p;
  logic             bad;
  logic             nx_lt;
  logic             fits;
  logic             at_tgt;
  logic             nx_le_tgt;
  logic             merge;
  logic [PW_W-1:0]  msum;
  logic [PW_W-1:0]  best_chk;
  logic [PW_W-1:0]  best_mrg;
  logic [NEED_W-1:0] need_w;
  logic [NEED_W-1:0] req_words;
  logic [TGT_W-1:0] tgt_w;
  logic [OFF_W-1:0] pay_w;
  logic             pool_has_block;

  ffpa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_WORDS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  function automatic logic [LRG_W-1:0] lrg_of(input logic [PW_W-1:0] b);
    logic [PW_W+2:0] by;
    by = {b - PW_W'(1), 3'b000};
    return (b == '0) ? '0 : LRG_W'(by);
  endfunction

  // Request size rounded up to words, plus one header word.
  assign req_words = NEED_W'(({1'b0, req_r.request_bytes} + 15'd7) >> 3);
  assign need_w    = req_words + NEED_W'(1);
  assign tgt_w     = req_r.block_offset[OFF_W-1:3] - TGT_W'(1);

  assign hdr       = fresh_r ? ent_t'(rdata) : cur_r;
  assign nxh       = ent_t'(rdata);
  assign nx_sum    = PS_W'(p_r) + PS_W'(hdr.size);
  assign cur_sum   = PS_W'(p_r) + PS_W'(cur_r.size);
  assign nx_p      = nx_sum[PW_W-1:0];
  assign bad       = (hdr.size == '0) || (nx_sum > PS_W'(pool_words));
  assign nx_lt     = nx_sum < PS_W'(pool_words);
  assign fits      = !hdr.alloc && (CW'(need_w) <= CW'(hdr.size));
  assign at_tgt    = CW'(p_r) == CW'(tgt_w);
  assign nx_le_tgt = CW'(nx_p) <= CW'(tgt_w);
  assign merge     = !nxh.alloc && (nxh.size != '0);
  assign msum      = cur_r.size + nxh.size;
  assign best_chk  = (!hdr.alloc && (hdr.size > best_r)) ? hdr.size : best_r;
  assign best_mrg  = (cur_r.size > best_r) ? cur_r.size : best_r;
  assign pay_w     = OFF_W'({PS_W'(p_r) + PS_W'(1), 3'b000});
  assign pool_has_block = pool_words > PW_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FMT;
    end else begin
      state_r <= state_nxt;
    end
    req_r   <= req_nxt;
    p_r     <= p_nxt;
    cur_r   <= cur_nxt;
    fresh_r <= fresh_nxt;
    best_r  <= best_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    p_nxt     = p_r;
    cur_nxt   = cur_r;
    fresh_nxt = 1'b0;
    best_nxt  = best_r;
    res_nxt   = res_r;
    we        = 1'b0;
    waddr     = p_r[AW-1:0];
    wdata     = cur_r;
    re        = 1'b0;
    raddr     = nx_p[AW-1:0];
    sts       = '0;

    unique case (state_r)
      ST_FMT: begin
        // The whole pool past the reserved word becomes one free block.
        if (pool_has_block) begin
          we    = 1'b1;
          waddr = AW'(1);
          wdata = '{alloc: 1'b0, size: pool_words - PW_W'(1)};
        end
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        sts.idle = 1'b1;
        priority if (ctl.fmt) begin
          state_nxt = ST_FMT;
        end else if (ctl.start) begin
          req_nxt   = req;
          state_nxt = ST_START;
        end
      end

      ST_START: begin
        res_nxt   = '0;
        best_nxt  = '0;
        p_nxt     = PW_W'(1);
        state_nxt = ST_DONE;
        unique case (req_r.func)
          FUNC_ALLOC: begin
            if (req_r.request_bytes != '0 && pool_has_block) begin
              state_nxt = ST_CHK;
            end
          end
          FUNC_FREE: begin
            if (req_r.block_offset == '0) begin
              res_nxt.ok = 1'b1;
            end else if (req_r.block_offset[2:0] == 3'b000
                         && req_r.block_offset >= OFF_W'(16) && pool_has_block) begin
              state_nxt = ST_CHK;
            end
          end
          FUNC_QUERY: begin
            res_nxt.ok = 1'b1;
            if (pool_has_block) begin
              state_nxt = ST_CHK;
            end
          end
          default: begin
          end
        endcase
        if (state_nxt == ST_CHK) begin
          re        = 1'b1;
          raddr     = AW'(1);
          fresh_nxt = 1'b1;
        end
      end

      ST_CHK: begin
        cur_nxt = hdr;
        if (bad) begin
          res_nxt.ok            = (req_r.func == FUNC_QUERY);
          res_nxt.largest_bytes = lrg_of(best_r);
          state_nxt             = ST_DONE;
        end else begin
          unique case (req_r.func)
            FUNC_ALLOC: begin
              if (fits) begin
                we                     = 1'b1;
                wdata                  = '{alloc: 1'b1, size: PW_W'(need_w)};
                res_nxt.ok             = 1'b1;
                res_nxt.payload_offset = pay_w;
                if (CW'(need_w) != CW'(hdr.size)) begin
                  cur_nxt   = '{alloc: 1'b0, size: hdr.size - PW_W'(need_w)};
                  p_nxt     = PW_W'(CW'(p_r) + CW'(need_w));
                  state_nxt = ST_SPLIT;
                end else begin
                  state_nxt = ST_DONE;
                end
              end else if (nx_lt) begin
                re = 1'b1;
                if (hdr.alloc) begin
                  p_nxt     = nx_p;
                  fresh_nxt = 1'b1;
                end else begin
                  state_nxt = ST_MRG;
                end
              end else begin
                state_nxt = ST_DONE;
              end
            end
            FUNC_FREE: begin
              if (at_tgt) begin
                if (hdr.alloc) begin
                  we         = 1'b1;
                  wdata      = '{alloc: 1'b0, size: hdr.size};
                  res_nxt.ok = 1'b1;
                end
                state_nxt = ST_DONE;
              end else if (nx_lt && nx_le_tgt) begin
                re        = 1'b1;
                p_nxt     = nx_p;
                fresh_nxt = 1'b1;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              if (nx_lt) begin
                re = 1'b1;
                if (hdr.alloc) begin
                  p_nxt     = nx_p;
                  fresh_nxt = 1'b1;
                end else begin
                  state_nxt = ST_MRG;
                end
              end else begin
                res_nxt.largest_bytes = lrg_of(best_chk);
                state_nxt             = ST_DONE;
              end
            end
          endcase
        end
      end

      ST_MRG: begin
        if (merge) begin
          // Fold the free successor into this block and check it again.
          we        = 1'b1;
          wdata     = '{alloc: 1'b0, size: msum};
          cur_nxt   = '{alloc: 1'b0, size: msum};
          state_nxt = ST_CHK;
        end else begin
          if (req_r.func == FUNC_QUERY) begin
            best_nxt = best_mrg;
          end
          re        = 1'b1;
          raddr     = cur_sum[AW-1:0];
          p_nxt     = cur_sum[PW_W-1:0];
          fresh_nxt = 1'b1;
          state_nxt = ST_CHK;
        end
      end

      ST_SPLIT: begin
        we        = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        sts.done = 1'b1;
        if (ctl.res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

  // The walk only reads forward, so a read never meets a write to the same word.
  a_no_rw_same_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re && (waddr == raddr)))
    else $error("header read and write hit the same word in one cycle");

  // Every header that is examined lies inside the pool.
  a_walk_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK) |-> (p_r < pool_words))
    else $error("chain walk left the pool");

  // An allocated header is written only when an allocate finds its block.
  a_alloc_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && wdata.alloc) |-> (state_r == ST_CHK && req_r.func == FUNC_ALLOC && fits))
    else $error("allocated header written outside a fitting allocate");

  // A split always finishes the request in the next cycle.
  a_split_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPLIT) |=> (state_r == ST_DONE))
    else $error("split did not complete the request");

endmodule

`default_nettype wire

@@ rtl/core/first_fit_pool_allocator.sv @@
// Top level of the first-fit pool allocator: handshakes, pool size and result register.
//
//  channel   direction  handshake              payload
//  in_*      input      in_valid / in_stall    in_data  (func, request_bytes, block_offset)
//  out_*     output     out_valid / out_stall  out_data (ok, payload_offset, largest_bytes)
//  cfg_*     input      cfg_valid / cfg_ready  cfg_data (pool_bytes)
//
// A request walks the header RAM from word 1, one block header at a time. In an allocate
// or a query every free block that is stepped over is first merged with a free successor,
// and a fitting block may have its remainder split off. A new request is taken only when
// the walker is idle again.
// Reset (synchronous, active low) and every pool_bytes write format the pool by writing
// the single free header at word 1, if the pool holds one; no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
// in_stall is high from the cycle after a request is accepted until the walker is idle
// again, during a format, and while a pool_bytes write is offered.
`default_nettype none

module first_fit_pool_allocator #(
  parameter int POOL_WORDS = ffpa_pkg::POOL_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire ffpa_pkg::in_t                in_data,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      ffpa_pkg::out_t               out_data,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [ffpa_pkg::CFG_W-1:0]   cfg_data
);

  import ffpa_pkg::*;

  localparam int PW_W = $clog2(POOL_WORDS + 1);
  localparam int CW   = (PW_W > NEED_W) ? PW_W : NEED_W;

  // Pool length in words after reset: the reset size rounded up and saturated.
  localparam int RST_RAW   = (int'(CFG_RST) + 7) / 8;
  localparam int RST_WORDS = (RST_RAW > POOL_WORDS) ? POOL_WORDS : RST_RAW;

  logic [PW_W-1:0]   pool_words_r, pool_words_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic [NEED_W-1:0] cfg_words;
  logic              cfg_wr;
  logic              res_ready;
  ctl_t              ctl;
  sts_t              sts;
  out_t              res;

  ffpa_walk #(
    .POOL_WORDS (POOL_WORDS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .req        (in_data),
    .pool_words (pool_words_r),
    .sts        (sts),
    .res        (res)
  );

  // A pool_bytes write is taken only while the walker sits idle, and it wins over
  // a request offered in the same cycle.
  assign cfg_ready = sts.idle;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = !sts.idle || cfg_valid;

  // The output register can take a result when it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  assign ctl.start     = in_valid && !in_stall;
  assign ctl.fmt       = cfg_wr;
  assign ctl.res_ready = res_ready;

  // Round the byte count up to words and clamp it to the store's depth.
  assign cfg_words = NEED_W'(({1'b0, cfg_data} + 15'd7) >> 3);

  always_comb begin
    pool_words_nxt = pool_words_r;
    if (cfg_wr) begin
      pool_words_nxt = (CW'(cfg_words) > CW'(POOL_WORDS)) ? PW_W'(POOL_WORDS)
                                                          : PW_W'(cfg_words);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (sts.done && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_words_r <= PW_W'(RST_WORDS);
      out_valid_r  <= 1'b0;
    end else begin
      pool_words_r <= pool_words_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A result moves into the output register only when the register can take it.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_r))
    else $error("pending result overwritten");

  // The pool never grows beyond the header store.
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    PW_W'(POOL_WORDS) >= pool_words_r)
    else $error("pool length exceeds the header store");

  // The walker is never started and reformatted in the same cycle.
  a_start_vs_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.start && ctl.fmt))
    else $error("request and pool format issued together");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the first-fit pool allocator: directed and random requests.
module testbench;
  import ffpa_pkg::*;

  // The fourth function code is not decoded by the block; it must answer all zeros.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int POOL_WORDS = POOL_WORDS_DEF;
  // Cycles that the receiver refuses replies during the backpressure test.
  localparam int LONG_HOLD_CYCLES = 400;
  // Upper bound on the walk of one request: every header it examines plus merges.
  localparam int WALK_CYCLES = 2 * POOL_WORDS + 16;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  first_fit_pool_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Replies predicted for accepted requests, oldest first.
  out_t        expected_replies[$];
  // Payload offsets of blocks the predictor currently holds as allocated.
  logic [OFF_W-1:0] live_blocks[$];
  int          error_count = 0;
  // When set, neither side starts new idle bursts.
  bit          calm = 1'b0;
  logic        long_hold = 1'b0;
  int          stall_burst = 0;
  event        long_hold_go;

  // ---------------------------------------------------------------------------
  // Pool predictor. The pool is an array of signed header words; word 0 is
  // reserved, so the block chain starts at word 1. A positive header is a free
  // block and a negative one is allocated; the magnitude is the block size in
  // bytes including the header word itself.
  // ---------------------------------------------------------------------------
  int          pool_hdr[POOL_WORDS];
  int unsigned pool_len;

  // Formats the pool as a single free block covering everything after word 0.
  // The size is rounded up to whole words and saturated at the store size; a
  // pool of fewer than two words holds no block at all.
  function automatic void pool_format(logic [CFG_W-1:0] bytes);
    int unsigned total;
    total = bytes;
    total = (total + 7) & ~32'd7;
    if (total > POOL_WORDS * 8) total = POOL_WORDS * 8;
    foreach (pool_hdr[i]) pool_hdr[i] = 0;
    pool_len = total / 8;
    if (pool_len >= 2) pool_hdr[1] = (pool_len - 1) * 8;
  endfunction

  function automatic int unsigned hdr_words(int h);
    return ((h < 0) ? -h : h) / 8;
  endfunction

  // Absorbs the following block into the free block at word p if that block
  // is free too. The absorbed header stays in the store but is off the chain.
  function automatic bit merge_next(int unsigned p);
    int unsigned nx;
    nx = p + hdr_words(pool_hdr[p]);
    if (nx < pool_len && pool_hdr[nx] > 0) begin
      pool_hdr[p] += pool_hdr[nx];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // A walk stops on a header of size zero or one that runs past the pool end.
  function automatic bit chain_broken(int unsigned p, int unsigned step);
    return step == 0 || p + step > pool_len;
  endfunction

  // First fit. A free block that is too small first swallows its free
  // neighbors and is then tried again; the tail of a fitting block is split
  // off as a new free block unless the fit is exact.
  function automatic int unsigned alloc_first_fit(logic [REQ_W-1:0] bytes);
    int          need;
    int          h;
    int unsigned p;
    int unsigned step;
    if (bytes == 0) return 0;
    need = ((int'(bytes) + 7) & ~7) + 8;
    p = 1;
    while (p < pool_len) begin
      h = pool_hdr[p];
      step = hdr_words(h);
      if (chain_broken(p, step)) break;
      if (need <= h) begin
        pool_hdr[p] = -need;
        if (h != need) pool_hdr[p + need / 8] = h - need;
        return (p + 1) * 8;
      end
      if (h < 0 || !merge_next(p)) p += step;
    end
    return 0;
  endfunction

  // A free is honored only for the payload of a block that is on the chain
  // and allocated. A null offset is a harmless no-op.
  function automatic bit free_block(logic [OFF_W-1:0] off);
    int unsigned target;
    int unsigned p;
    int unsigned step;
    int          h;
    if (off == 0) return 1'b1;
    if (off[2:0] != 3'd0 || off < 16) return 1'b0;
    target = off / 8 - 1;
    p = 1;
    while (p < pool_len && p <= target) begin
      h = pool_hdr[p];
      step = hdr_words(h);
      if (chain_broken(p, step)) break;
      if (p == target) begin
        if (h < 0) begin
          pool_hdr[p] = -h;
          return 1'b1;
        end
        return 1'b0;
      end
      p += step;
    end
    return 1'b0;
  endfunction

  // Largest free payload; merges free neighbors along the way, like allocate.
  function automatic int unsigned query_largest();
    int          best;
    int          h;
    int unsigned p;
    int unsigned step;
    best = 0;
    p = 1;
    while (p < pool_len) begin
      h = pool_hdr[p];
      step = hdr_words(h);
      if (chain_broken(p, step)) break;
      if (h < 0) begin
        p += step;
      end else if (!merge_next(p)) begin
        if (h > best) best = h;
        p += step;
      end
    end
    return (best >= 8) ? best - 8 : 0;
  endfunction

  function automatic out_t predict_reply(in_t req);
    out_t        a;
    int unsigned v;
    a = '0;
    case (req.func)
      FUNC_ALLOC: begin
        v = alloc_first_fit(req.request_bytes);
        a.payload_offset = v[OFF_W-1:0];
        a.ok = (v != 0);
      end
      FUNC_FREE: begin
        a.ok = free_block(req.block_offset);
      end
      FUNC_QUERY: begin
        v = query_largest();
        a.largest_bytes = v[LRG_W-1:0];
        a.ok = 1'b1;
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checking. Every reply taken from the block is compared field by
  // field with the oldest prediction. Failures are counted, not fatal.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : reply_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding", int'(out_data), 0);
      end else begin
        want = expected_replies.pop_front();
        if (out_data.ok !== want.ok)
          report_mismatch("ok", int'(out_data.ok), int'(want.ok));
        if (out_data.payload_offset !== want.payload_offset)
          report_mismatch("payload_offset", int'(out_data.payload_offset),
                          int'(want.payload_offset));
        if (out_data.largest_bytes !== want.largest_bytes)
          report_mismatch("largest_bytes", int'(out_data.largest_bytes),
                          int'(want.largest_bytes));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. It stalls in random bursts unless the run is calm, and stalls
  // solidly while a long hold is in force.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (stall_burst != 0) begin
      out_stall <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_burst <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // The long hold is timed here, apart from the sender, so that the sender can
  // keep offering requests until the block backs up and stalls its input.
  initial begin
    forever begin
      @(long_hold_go);
      @(negedge clk);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(negedge clk);
      long_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. A request is presented at a falling edge and held until a
  // rising edge finds in_stall low. Valid is left high afterwards, so the next
  // step must either present the next request or drop valid at the next
  // falling edge; every caller does one of the two.
  // ---------------------------------------------------------------------------
  task automatic send_request(in_t req);
    out_t a;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    a = predict_reply(req);
    expected_replies.push_back(a);
    if (req.func == FUNC_ALLOC && a.ok) live_blocks.push_back(a.payload_offset);
    if (req.func == FUNC_FREE && a.ok) begin
      for (int i = 0; i < live_blocks.size(); i++) begin
        if (live_blocks[i] == req.block_offset) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic in_t make_request(logic [FUNC_W-1:0] func, int bytes, int off);
    in_t r;
    r.func = func;
    r.request_bytes = REQ_W'(bytes);
    r.block_offset = OFF_W'(off);
    return r;
  endfunction

  // Writes pool_bytes once the block has answered everything and gone idle.
  // The write reformats the pool, so the live block list starts over.
  task automatic write_pool_size(logic [CFG_W-1:0] bytes);
    idle_input(1);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = bytes;
    do @(posedge clk); while (!cfg_ready);
    pool_format(bytes);
    live_blocks.delete();
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Random request. Most traffic is allocations of modest size and frees of
  // blocks that really are allocated, so the pool fills, fragments and
  // coalesces. The rest is queries, oversized or zero requests, frees of
  // bogus offsets and the undecoded function. Unused fields carry noise.
  function automatic in_t random_request();
    in_t r;
    int  k;
    r.request_bytes = REQ_W'($urandom);
    r.block_offset = OFF_W'($urandom);
    k = $urandom_range(0, 99);
    if (k < 45) begin
      r.func = FUNC_ALLOC;
      case ($urandom_range(0, 9))
        0: r.request_bytes = $urandom_range(0, 1) ? '0 : REQ_W'($urandom);
        1: r.request_bytes = REQ_W'($urandom_range(1, pool_len * 8 + 8));
        2, 3: r.request_bytes = REQ_W'($urandom_range(65, 400));
        default: r.request_bytes = REQ_W'($urandom_range(1, 64));
      endcase
    end else if (k < 80) begin
      r.func = FUNC_FREE;
      k = $urandom_range(0, 9);
      if (live_blocks.size() != 0 && k < 7)
        r.block_offset = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      else if (k < 8)
        r.block_offset = OFF_W'($urandom_range(2, POOL_WORDS - 1) * 8);
      else if (k < 9)
        r.block_offset = '0;
    end else if (k < 95) begin
      r.func = FUNC_QUERY;
    end else begin
      r.func = FUNC_UNUSED;
    end
    return r;
  endfunction

  task automatic run_random_items(int count);
    repeat (count) begin
      send_request(random_request());
      if (!calm && $urandom_range(0, 3) == 0) idle_input($urandom_range(1, 10));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Hand-picked requests on the pool as it comes out of reset: a full-pool
  // exact fit, an exhausted pool, zero and oversized requests, null, bogus,
  // misaligned and repeated frees, splitting and merging of neighbors, and
  // the undecoded function with every field bit set.
  task automatic test_directed_ops();
    send_request(make_request(FUNC_QUERY, 0, 0));
    send_request(make_request(FUNC_ALLOC, 0, 0));
    send_request(make_request(FUNC_ALLOC, 16383, 8191));
    send_request(make_request(FUNC_ALLOC, 8176, 0));
    send_request(make_request(FUNC_QUERY, 0, 0));
    send_request(make_request(FUNC_ALLOC, 1, 0));
    send_request(make_request(FUNC_FREE, 0, 16));
    send_request(make_request(FUNC_FREE, 0, 16));
    send_request(make_request(FUNC_FREE, 16383, 0));
    send_request(make_request(FUNC_FREE, 0, 20));
    send_request(make_request(FUNC_FREE, 0, 8));
    send_request(make_request(FUNC_FREE, 0, 8191));
    send_request(make_request(FUNC_ALLOC, 1, 0));
    send_request(make_request(FUNC_ALLOC, 9, 0));
    send_request(make_request(FUNC_ALLOC, 100, 0));
    send_request(make_request(FUNC_FREE, 0, 32));
    send_request(make_request(FUNC_FREE, 0, 16));
    // Offset 24 lies inside the first block, not at the start of one.
    send_request(make_request(FUNC_FREE, 0, 24));
    // Only fits once the two freed neighbors are merged.
    send_request(make_request(FUNC_ALLOC, 32, 0));
    send_request(make_request(FUNC_QUERY, 0, 0));
    send_request(make_request(FUNC_UNUSED, 16383, 8191));
    send_request(make_request(FUNC_ALLOC, 8192, 0));
  endtask

  // Pool sizes at and beyond the ends of the range: one minimal block, no
  // block at all, rounding up, saturation at the store size, and back.
  task automatic test_pool_sizes();
    logic [CFG_W-1:0] sizes[7];
    sizes = '{14'd16, 14'd0, 14'd8, 14'd17, 14'd16383, 14'd4000, 14'd8192};
    foreach (sizes[i]) begin
      write_pool_size(sizes[i]);
      run_random_items(12);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so
  // the result register fills and the block must stall its input.
  task automatic test_backpressure();
    write_pool_size(14'd1024);
    ->long_hold_go;
    repeat (12) send_request(random_request());
  endtask

  // Random traffic over a series of pool sizes: the full pool, small pools and sizes from the whole range.
  task automatic test_random_traffic();
    repeat (8) begin
      case ($urandom_range(0, 3))
        0: write_pool_size(14'd8192);
        1: write_pool_size(CFG_W'($urandom_range(16, 256)));
        default: write_pool_size(CFG_W'($urandom_range(16, 8192)));
      endcase
      run_random_items(115);
    end
  endtask

  // Back-to-back requests with neither side idling.
  task automatic test_steady_stream();
    calm = 1'b1;
    write_pool_size(14'd8192);
    run_random_items(140);
  endtask

  initial begin
    pool_format(CFG_RST);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_pool_sizes();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();

    // Let every reply come back, then give the block time to show a stray one.
    idle_input(1);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (WALK_CYCLES) @(negedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Safety net against a hung handshake; far beyond the slowest legal run.
  initial begin
    #60000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
